// ===== src/first_seen_category_id_assigner_unit_assert.svh =====
// Assertion macros shared by the dictionary encoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef FIRST_SEEN_CATEGORY_ID_ASSIGNER_UNIT_ASSERT_SVH
`define FIRST_SEEN_CATEGORY_ID_ASSIGNER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSCA_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fsca: same-cycle check failed");

// Next-cycle implication.
`define FSCA_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fsca: next-cycle check failed");

`endif

// ===== src/fsca_pkg.sv =====
// Shared constants and types of the dictionary encoder.
// Depends on nothing; used by fsca_lookup_ctrl, the top level and the bench.
`default_nettype none

package fsca_pkg;

   localparam int DEF_FEATURES = 4;
   localparam int DEF_ENTRIES  = 256;

   localparam int SLOT_W = 2;
   localparam int KEY_W  = 32;
   localparam int BIN_W  = 8;

   // Number of slot codes the slot field can express.
   localparam int SLOT_CODES = 1 << SLOT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== src/fsca_key_mem.sv =====
// Key store: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module fsca_key_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/fsca_lookup_ctrl.sv =====
// Lookup sequencer: scans a dictionary with one shared key compare,
// appends new keys and keeps the per-dictionary entry counts.
// Depends on fsca_pkg and the assertion macro header.
`default_nettype none
`include "first_seen_category_id_assigner_unit_assert.svh"

module fsca_lookup_ctrl
   import fsca_pkg::*;
#(
   parameter int DICTS   = 4,
   parameter int ENTRIES = 256,
   parameter int AW      = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [SLOT_W-1:0] req_feature_slot,
   input  wire logic [KEY_W-1:0]  req_hashed_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [BIN_W-1:0]  rsp_bin_index,
   output logic                   rsp_is_new,
   output logic                   rsp_overflow,
   output logic                   mem_wr_en,
   output logic      [AW-1:0]     mem_wr_addr,
   output logic      [KEY_W-1:0]  mem_wr_data,
   output logic      [AW-1:0]     mem_rd_addr,
   input  wire logic [KEY_W-1:0]  mem_rd_data
);

   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int DIW = (DICTS > 1) ? $clog2(DICTS) : 1;
   localparam int SCW = SLOT_W + 1;

   state_type state_ff, state_in;

   logic [CW-1:0]    cnt_ff [DICTS];
   logic [DIW-1:0]   dict_ff, dict_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             pend_ff, pend_in;
   logic [CW-1:0]    res_idx_ff, res_idx_in;
   logic             res_new_ff, res_new_in;
   logic             res_ovf_ff, res_ovf_in;

   logic             accept;
   logic             slot_ok;
   logic [DIW-1:0]   req_dict;
   logic             issue;
   logic             hit;
   logic             full;
   logic             append;
   logic [CW+BIN_W-1:0] res_ext;

   assign accept   = req_valid && !req_stall;
   assign slot_ok  = {1'b0, req_feature_slot} < SCW'(DICTS);
   assign req_dict = DIW'(req_feature_slot);
   assign issue    = rd_idx_ff < count_ff;
   assign hit      = pend_ff && (mem_rd_data == key_ff);
   assign full     = count_ff == CW'(ENTRIES);
   assign append   = (state_ff == ST_SCAN) && !hit && !issue && !pend_ff && !full;

   assign mem_rd_addr = base_ff + AW'(rd_idx_ff);
   assign mem_wr_en   = append;
   assign mem_wr_addr = base_ff + AW'(count_ff);
   assign mem_wr_data = key_ff;

   always_comb begin
      state_in   = state_ff;
      dict_in    = dict_ff;
      key_in     = key_ff;
      base_in    = base_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = rd_idx_ff;
      pend_in    = 1'b0;
      res_idx_in = res_idx_ff;
      res_new_in = res_new_ff;
      res_ovf_in = res_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dict_in    = req_dict;
               key_in     = req_hashed_value;
               base_in    = AW'(req_dict) * AW'(ENTRIES);
               count_in   = cnt_ff[req_dict];
               rd_idx_in  = '0;
               res_idx_in = '0;
               res_new_in = 1'b0;
               res_ovf_in = 1'b0;
               if (slot_ok) begin
                  state_in = ST_SCAN;
               end else begin
                  // no dictionary behind this slot: reject at once
                  res_ovf_in = 1'b1;
                  state_in   = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_idx_in = cmp_idx_ff;
               state_in   = ST_RESP;
            end else if (issue) begin
               // advance the read pointer while the previous key compares
               rd_idx_in = rd_idx_ff + CW'(1);
               pend_in   = 1'b1;
            end else if (!pend_ff) begin
               if (full) begin
                  res_ovf_in = 1'b1;
               end else begin
                  res_idx_in = count_ff;
                  res_new_in = 1'b1;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         for (int d = 0; d < DICTS; d++) begin
            cnt_ff[d] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (append) begin
            cnt_ff[dict_ff] <= count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dict_ff    <= dict_in;
      key_ff     <= key_in;
      base_ff    <= base_in;
      count_ff   <= count_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      res_idx_ff <= res_idx_in;
      res_new_ff <= res_new_in;
      res_ovf_ff <= res_ovf_in;
   end

   assign res_ext       = {{BIN_W{1'b0}}, res_idx_ff};
   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = state_ff == ST_RESP;
   assign rsp_bin_index = res_ext[BIN_W-1:0];
   assign rsp_is_new    = res_new_ff;
   assign rsp_overflow  = res_ovf_ff;

   `FSCA_ASSERT_IMP(a_busy_while_result, clock, reset, rsp_valid, req_stall)
   `FSCA_ASSERT_IMP(a_new_or_ovf, clock, reset, rsp_valid, !(rsp_is_new && rsp_overflow))
   `FSCA_ASSERT_IMP(a_ovf_zero_bin, clock, reset, rsp_valid && rsp_overflow, rsp_bin_index == '0)
   `FSCA_ASSERT_NXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE)
   `FSCA_ASSERT_IMP(a_count_range, clock, reset, state_ff == ST_SCAN, count_ff <= CW'(ENTRIES))
   `FSCA_ASSERT_NXT(a_append_done, clock, reset, append, rsp_valid && rsp_is_new)

endmodule

`default_nettype wire

// ===== src/first_seen_category_id_assigner_unit.sv =====
// A lookup scans the addressed dictionary: each stored key is read from the key store and then
// compared with the item; a hit ends the scan, a miss appends the key or reports overflow when full.
// The block takes no new item until the result of the last one is taken; the scan reads one
// stored key per cycle through the single key-store read port.
// Reset: synchronous, active high; clears all entry counts and the sequencer.
// Depends on fsca_pkg, fsca_key_mem and fsca_lookup_ctrl.
`default_nettype none

module first_seen_category_id_assigner_unit
   import fsca_pkg::*;
#(
   parameter int FEATURES = DEF_FEATURES,
   parameter int ENTRIES  = DEF_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [SLOT_W-1:0] req_feature_slot,
   input  wire logic [KEY_W-1:0]  req_hashed_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [BIN_W-1:0]  rsp_bin_index,
   output logic                   rsp_is_new,
   output logic                   rsp_overflow
);

   // Only the slots the slot field can name get a dictionary.
   localparam int DICTS = (FEATURES < SLOT_CODES) ? FEATURES : SLOT_CODES;
   localparam int DEPTH = DICTS * ENTRIES;
   localparam int AW    = $clog2(DEPTH);

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [KEY_W-1:0] mem_wr_data;
   logic [AW-1:0]    mem_rd_addr;
   logic [KEY_W-1:0] mem_rd_data;

   fsca_lookup_ctrl #(
      .DICTS   (DICTS),
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_feature_slot (req_feature_slot),
      .req_hashed_value (req_hashed_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_overflow     (rsp_overflow),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   fsca_key_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (KEY_W)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== bench/first_seen_category_id_assigner_unit_test.sv =====
// Self-checking bench for the first-seen category ID assigner: a directed table, then random
// items under four idling patterns, every result checked against its typed table row or a local dictionary model.
// Depends on fsca_pkg and first_seen_category_id_assigner_unit.
module first_seen_category_id_assigner_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fsca_pkg::*;

   localparam int FEATURES       = DEF_FEATURES;
   localparam int ENTRIES        = DEF_ENTRIES;
   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int PHASES         = 4;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = ENTRIES + 16;
   localparam int WATCHDOG_LIMIT = 8 * (ENTRIES + HOLDOFF_CYCLES);
   localparam int MAX_PRINTED    = 40;

   // Idle percentages per phase: none, sender only, receiver only, both.
   localparam int SEND_IDLE_PCT [PHASES] = '{0, 65, 0, 25};
   localparam int RSP_STALL_PCT [PHASES] = '{0, 0, 65, 25};

   typedef struct packed {
      logic [BIN_W-1:0] bin_index;
      logic             is_new;
      logic             overflow;
   } encoding_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key;
      logic              typed;
      encoding_type      result;
   } dir_row_type;

   // Rows marked typed carry their result; the others are checked by the model.
   localparam dir_row_type DIRECTED [17] = '{
      '{2'd0, 32'h0000_0000, 1'b1, '{8'd0, 1'b1, 1'b0}},
      '{2'd0, 32'hFFFF_FFFF, 1'b1, '{8'd1, 1'b1, 1'b0}},
      '{2'd0, 32'h0000_0000, 1'b1, '{8'd0, 1'b0, 1'b0}},
      '{2'd0, 32'hFFFF_FFFF, 1'b1, '{8'd1, 1'b0, 1'b0}},
      '{2'd3, 32'hFFFF_FFFF, 1'b1, '{8'd0, 1'b1, 1'b0}},
      '{2'd3, 32'h0000_0000, 1'b1, '{8'd1, 1'b1, 1'b0}},
      '{2'd1, 32'hA5A5_A5A5, 1'b1, '{8'd0, 1'b1, 1'b0}},
      '{2'd2, 32'h5A5A_5A5A, 1'b1, '{8'd0, 1'b1, 1'b0}},
      '{2'd1, 32'h5A5A_5A5A, 1'b0, '{8'd0, 1'b0, 1'b0}},
      '{2'd2, 32'hA5A5_A5A5, 1'b0, '{8'd0, 1'b0, 1'b0}},
      '{2'd0, 32'h8000_0000, 1'b0, '{8'd0, 1'b0, 1'b0}},
      '{2'd0, 32'h0000_0001, 1'b0, '{8'd0, 1'b0, 1'b0}},
      '{2'd0, 32'h7FFF_FFFF, 1'b0, '{8'd0, 1'b0, 1'b0}},
      '{2'd0, 32'h8000_0000, 1'b0, '{8'd0, 1'b0, 1'b0}},
      '{2'd2, 32'h5A5A_5A5A, 1'b1, '{8'd0, 1'b0, 1'b0}},
      '{2'd3, 32'h0000_0000, 1'b1, '{8'd1, 1'b0, 1'b0}},
      '{2'd1, 32'hA5A5_A5A5, 1'b1, '{8'd0, 1'b0, 1'b0}}
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [SLOT_W-1:0] req_feature_slot = '0;
   logic [KEY_W-1:0]  req_hashed_value = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [BIN_W-1:0]  rsp_bin_index;
   logic              rsp_is_new;
   logic              rsp_overflow;

   logic [KEY_W-1:0] dict_keys [FEATURES][ENTRIES];
   int unsigned      dict_fill [FEATURES];
   encoding_type     pending_encodings [$];
   int               error_count      = 0;
   int               quiet_cycles     = 0;
   int               send_idle_pct    = 0;
   int               rsp_stall_pct    = 0;
   int               holdoff_requests = 0;
   int               holdoffs_served  = 0;
   int               holdoff_left     = 0;
   int               heavy_slot;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   first_seen_category_id_assigner_unit #(
      .FEATURES(FEATURES),
      .ENTRIES (ENTRIES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_feature_slot(req_feature_slot),
      .req_hashed_value(req_hashed_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_is_new      (rsp_is_new),
      .rsp_overflow    (rsp_overflow)
   );

   // Look the key up in the slot's dictionary and append it when new and room is left.
   function automatic encoding_type encode_category(input logic [SLOT_W-1:0] slot,
                                                    input logic [KEY_W-1:0] key);
      encoding_type res;
      int unsigned  fill;
      res = '0;
      if (slot >= FEATURES) begin
         res.overflow = 1'b1;
         return res;
      end
      fill = dict_fill[slot];
      for (int i = 0; i < fill; i++) begin
         if (dict_keys[slot][i] == key) begin
            res.bin_index = BIN_W'(i);
            return res;
         end
      end
      if (fill >= ENTRIES) begin
         res.overflow = 1'b1;
         return res;
      end
      dict_keys[slot][fill] = key;
      dict_fill[slot]       = fill + 1;
      res.bin_index         = BIN_W'(fill);
      res.is_new            = 1'b1;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Offer one item after a random gap and hold it until the block takes it.
   task automatic offer_item(input logic [SLOT_W-1:0] slot, input logic [KEY_W-1:0] key,
                             input bit typed, input encoding_type typed_result);
      int           gap;
      encoding_type predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_feature_slot <= slot;
      req_hashed_value <= key;
      do @(posedge clock); while (req_stall);
      predicted = encode_category(slot, key);
      pending_encodings.push_back(typed ? typed_result : predicted);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoffs_served != holdoff_requests) begin
         rsp_stall       <= 1'b1;
         holdoff_left    <= HOLDOFF_CYCLES - 1;
         holdoffs_served <= holdoffs_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      encoding_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_encodings.size() == 0) begin
               report_mismatch("result with no item pending", 1, 0);
            end else begin
               want = pending_encodings.pop_front();
               if (rsp_bin_index !== want.bin_index)
                  report_mismatch("bin_index", rsp_bin_index, want.bin_index);
               if (rsp_is_new !== want.is_new)
                  report_mismatch("is_new", rsp_is_new, want.is_new);
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", rsp_overflow, want.overflow);
            end
         end
      end
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key;
      int unsigned       fill;
      for (int f = 0; f < FEATURES; f++) dict_fill[f] = 0;
      heavy_slot = $urandom_range(FEATURES - 1);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r])
         offer_item(DIRECTED[r].slot, DIRECTED[r].key, DIRECTED[r].typed, DIRECTED[r].result);

      for (int phase = 0; phase < PHASES; phase++) begin
         send_idle_pct = SEND_IDLE_PCT[phase];
         rsp_stall_pct <= RSP_STALL_PCT[phase];
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // Hold off the receiver while items keep coming, so the block backs up.
            if (phase == 0 && n == 100) holdoff_requests <= holdoff_requests + 1;
            // Favor one slot so its dictionary fills up and starts rejecting new values.
            if ($urandom_range(99) < 40)
               slot = heavy_slot;
            else
               slot = $urandom_range(FEATURES - 1);
            fill = dict_fill[slot];
            if (fill != 0 && $urandom_range(99) < 45)
               key = dict_keys[slot][$urandom_range(fill - 1)];
            else
               key = $urandom();
            offer_item(slot, key, 1'b0, '0);
         end
         // Pause the sender until every result of the phase is back.
         req_valid <= 1'b0;
         while (pending_encodings.size() != 0) @(posedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/fsca_pkg.sv
src/fsca_key_mem.sv
src/fsca_lookup_ctrl.sv
src/first_seen_category_id_assigner_unit.sv
bench/first_seen_category_id_assigner_unit_test.sv
